[src/scb_pkg.sv]
// Shared types, widths and codes for the stream context binding table.
package scb_pkg;

  localparam int ADDR_W         = 40;
  localparam int SID_W          = 16;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 2;
  localparam int BIDX_W         = 3;
  localparam int GIDX_W         = 4;
  localparam int SID_BITS_W     = 4;
  localparam int DEF_NUM_BANKS  = 8;
  localparam int DEF_NUM_GROUPS = 16;

  // APB side: one 32-bit register at byte address 0
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] CFG_IDX_SID_BITS = '0;
  localparam logic [SID_BITS_W-1:0] SID_BITS_RESET = 4'd15;

  localparam logic [CMD_W-1:0] CMD_BIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNBIND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SID_W-1:0]  sid;
    logic [ADDR_W-1:0] table_address;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                bank_found;
    logic [BIDX_W-1:0]   bank_index;
    logic [GIDX_W-1:0]   group_index;
    logic                bank_enabled;
    logic                released_valid;
    logic [BIDX_W-1:0]   released_bank;
  } result_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic free_found;
  } scan_flags_t;

endpackage

[src/scb_scan.sv]
// Shared table scanner: walks entries one per cycle through a single comparator.
module scb_scan
  import scb_pkg::*;
#(
  parameter int IW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [IW-1:0]     last,
  input  logic              entry_valid,
  input  logic [ADDR_W-1:0] a_op,
  input  logic [ADDR_W-1:0] b_op,
  output logic [IW-1:0]     rd_idx,
  output logic [IW-1:0]     cmp_idx,
  output logic              match,
  output scan_flags_t       flags,
  output logic [IW-1:0]     hit_idx,
  output logic [IW-1:0]     free_idx
);

  logic active;
  logic cmp_live;
  logic cmp_last;
  logic done_q;
  logic hit;
  logic free_found;

  // the one comparator of the block
  assign match = cmp_live && entry_valid && (a_op == b_op);

  assign flags.done       = done_q;
  assign flags.hit        = hit;
  assign flags.free_found = free_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      cmp_live   <= 1'b0;
      cmp_last   <= 1'b0;
      done_q     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      rd_idx     <= '0;
      cmp_idx    <= '0;
    end else begin
      // compare stage lines up with the registered memory read
      cmp_live <= active;
      cmp_idx  <= rd_idx;
      cmp_last <= active && (rd_idx == last);
      done_q   <= cmp_live && cmp_last;
      if (go) begin
        active     <= 1'b1;
        rd_idx     <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (active) begin
          if (rd_idx == last) begin
            active <= 1'b0;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        if (match && !hit) begin
          hit     <= 1'b1;
          hit_idx <= cmp_idx;
        end
        if (cmp_live && !entry_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
  end

endmodule

[src/stream_context_binding_table.sv]
// Top level of the stream context binding table: bank and group tables with their sequencer.
//
// A request is taken when start is high and busy is low; its single result is registered on result
// and flagged by done high for exactly one cycle, and the receiver cannot stall it. Requests that end
// up front (command 3 with status OK; address zero, or, except for remove, a stream id out of range,
// with status range) skip the scans. Otherwise one shared comparator visits one table entry per cycle:
// the bank scan, which ends the request if no bank fits, then the group scan (bind, unbind) or group
// sweep (remove); a bind that moves a group off another bank then reads and writes that bank's count,
// and a commit state ends the request. The next request can be accepted in the cycle the strobe is
// shown. No clearing pass is needed after reset: bank and group occupancy live in flip-flops cleared
// by reset.
module stream_context_binding_table
  import scb_pkg::*;
#(
  parameter int NUM_BANKS  = DEF_NUM_BANKS,
  parameter int NUM_GROUPS = DEF_NUM_GROUPS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  request_t          request,
  output logic              done,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int IW = (BW > GW) ? BW : GW;
  localparam int CW = $clog2(NUM_GROUPS + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_BSCAN  = 7'b0000010,
    S_GSCAN  = 7'b0000100,
    S_RSCAN  = 7'b0001000,
    S_OLDRD  = 7'b0010000,
    S_OLDWR  = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_t;

  state_t state, state_next;

  // tables: occupancy in flip-flops, contents in memories
  logic [ADDR_W-1:0] bank_addr_mem  [NUM_BANKS];
  logic [CW-1:0]     bank_cnt_mem   [NUM_BANKS];
  logic [SID_W-1:0]  grp_stream_mem [NUM_GROUPS];
  logic [BW-1:0]     grp_bank_mem   [NUM_GROUPS];
  logic [NUM_BANKS-1:0]  bank_valid;
  logic [NUM_GROUPS-1:0] grp_used;

  logic [ADDR_W-1:0] addr_rd;
  logic [CW-1:0]     cnt_rd;
  logic [SID_W-1:0]  stream_rd;
  logic [BW-1:0]     gbank_rd;

  // per-request registers
  request_t                req;
  logic [SID_BITS_W-1:0]   sid_bits;
  logic [BW-1:0]           bsel;
  logic                    bank_new;
  logic [CW-1:0]           b_cnt;
  logic [GW-1:0]           gsel;
  logic [BW-1:0]           gb;
  logic [CW-1:0]           rm_cnt;
  logic                    rel_v;
  logic [BW-1:0]           rel_b;

  // scanner hookup
  logic              scan_go;
  logic [IW-1:0]     scan_last;
  logic              entry_valid;
  logic [ADDR_W-1:0] a_op;
  logic [ADDR_W-1:0] b_op;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     cmp_idx;
  logic              match;
  scan_flags_t       flags;
  logic [IW-1:0]     hit_idx;
  logic [IW-1:0]     free_idx;

  logic [BW-1:0] rd_b, cmp_b, hit_b, free_b;
  logic [GW-1:0] rd_g, cmp_g, hit_g, free_g;

  logic    accept;
  logic    oor;
  logic    bad;
  logic    fin;
  result_t res_next;
  result_t res_base;

  // table update controls from the sequencer
  logic          cnt_we;
  logic [BW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [BW-1:0] cnt_raddr;
  logic          addr_we;
  logic          grp_we;
  logic          valid_set;
  logic          valid_clr;
  logic [BW-1:0] valid_clr_idx;
  logic          used_set;
  logic          used_clr;
  logic          rel_set;
  logic [BW-1:0] rel_idx;

  logic [CW-1:0] old_dec;
  logic [CW-1:0] b_dec;
  logic [CW-1:0] b_sub;
  logic [CW-1:0] b_inc;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  assign oor = (request.sid >> sid_bits) != '0;
  assign bad = (request.table_address == '0) || ((request.command != CMD_REMOVE) && oor);

  assign rd_b   = rd_idx[BW-1:0];
  assign cmp_b  = cmp_idx[BW-1:0];
  assign hit_b  = hit_idx[BW-1:0];
  assign free_b = free_idx[BW-1:0];
  assign rd_g   = rd_idx[GW-1:0];
  assign cmp_g  = cmp_idx[GW-1:0];
  assign hit_g  = hit_idx[GW-1:0];
  assign free_g = free_idx[GW-1:0];

  // counts never drop below zero
  assign old_dec = (cnt_rd != '0) ? cnt_rd - 1'b1 : '0;
  assign b_dec   = (b_cnt != '0) ? b_cnt - 1'b1 : '0;
  assign b_sub   = (b_cnt > rm_cnt) ? b_cnt - rm_cnt : '0;
  assign b_inc   = b_cnt + 1'b1;

  assign cnt_raddr = (state == S_OLDRD) ? gb : rd_b;

  // comparator operands: bank address, stream id, or a group's bank
  always_comb begin
    if (state == S_BSCAN) begin
      entry_valid = bank_valid[cmp_b];
      a_op        = req.table_address;
      b_op        = addr_rd;
    end else if (state == S_RSCAN) begin
      entry_valid = grp_used[cmp_g];
      a_op        = ADDR_W'(bsel);
      b_op        = ADDR_W'(gbank_rd);
    end else begin
      entry_valid = grp_used[cmp_g];
      a_op        = ADDR_W'(req.sid);
      b_op        = ADDR_W'(stream_rd);
    end
  end

  always_comb begin
    res_base                = '0;
    res_base.bank_found     = 1'b1;
    res_base.bank_index     = BIDX_W'(bsel);
    res_base.released_valid = rel_v;
    res_base.released_bank  = rel_v ? BIDX_W'(rel_b) : '0;
  end

  scb_scan #(
    .IW(IW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .go          (scan_go),
    .last        (scan_last),
    .entry_valid (entry_valid),
    .a_op        (a_op),
    .b_op        (b_op),
    .rd_idx      (rd_idx),
    .cmp_idx     (cmp_idx),
    .match       (match),
    .flags       (flags),
    .hit_idx     (hit_idx),
    .free_idx    (free_idx)
  );

  // sequencer
  always_comb begin
    state_next    = state;
    fin           = 1'b0;
    res_next      = '0;
    scan_go       = 1'b0;
    // the scanner checks its end index on every step, so hold it for the whole walk
    scan_last     = ((state == S_GSCAN) || (state == S_RSCAN)) ? IW'(NUM_GROUPS - 1)
                                                              : IW'(NUM_BANKS - 1);
    cnt_we        = 1'b0;
    cnt_waddr     = bsel;
    cnt_wdata     = b_inc;
    addr_we       = 1'b0;
    grp_we        = 1'b0;
    valid_set     = 1'b0;
    valid_clr     = 1'b0;
    valid_clr_idx = bsel;
    used_set      = 1'b0;
    used_clr      = 1'b0;
    rel_set       = 1'b0;
    rel_idx       = bsel;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (request.command == CMD_NOP) begin
            fin = 1'b1;
          end else if (bad) begin
            fin             = 1'b1;
            res_next.status = STATUS_RANGE;
          end else begin
            scan_go    = 1'b1;
            state_next = S_BSCAN;
          end
        end
      end
      S_BSCAN: begin
        if (flags.done) begin
          if (flags.hit || ((req.command == CMD_BIND) && flags.free_found)) begin
            scan_go    = 1'b1;
            scan_last  = IW'(NUM_GROUPS - 1);
            state_next = (req.command == CMD_REMOVE) ? S_RSCAN : S_GSCAN;
          end else begin
            // bind with no bank left; unbind or remove of an unknown table
            fin             = 1'b1;
            res_next.status = (req.command == CMD_BIND) ? STATUS_FULL : STATUS_OK;
            state_next      = S_IDLE;
          end
        end
      end
      S_GSCAN: begin
        if (flags.done) begin
          res_next = res_base;
          if (flags.hit) begin
            res_next.group_index = GIDX_W'(hit_g);
          end
          if (req.command == CMD_BIND) begin
            if (flags.hit) begin
              if (gb == bsel) begin
                // same pair already bound
                fin        = 1'b1;
                state_next = S_IDLE;
              end else begin
                state_next = S_OLDRD;
              end
            end else if (flags.free_found) begin
              state_next = S_COMMIT;
            end else begin
              fin             = 1'b1;
              res_next.status = STATUS_FULL;
              state_next      = S_IDLE;
            end
          end else begin
            if (flags.hit && (gb == bsel)) begin
              state_next = S_COMMIT;
            end else begin
              // stream unknown, or bound to another bank: left alone
              fin        = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
      end
      S_RSCAN: begin
        if (flags.done) begin
          state_next = S_COMMIT;
        end
      end
      S_OLDRD: begin
        state_next = S_OLDWR;
      end
      S_OLDWR: begin
        // group leaves its previous bank
        cnt_we    = 1'b1;
        cnt_waddr = gb;
        cnt_wdata = old_dec;
        if (old_dec == '0) begin
          valid_clr     = 1'b1;
          valid_clr_idx = gb;
          rel_set       = 1'b1;
          rel_idx       = gb;
        end
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        fin        = 1'b1;
        state_next = S_IDLE;
        res_next   = res_base;
        cnt_we     = 1'b1;
        case (req.command)
          CMD_BIND: begin
            res_next.group_index  = GIDX_W'(gsel);
            res_next.bank_enabled = bank_new;
            cnt_wdata             = b_inc;
            grp_we                = 1'b1;
            used_set              = 1'b1;
            valid_set             = bank_new;
            addr_we               = bank_new;
          end
          CMD_UNBIND: begin
            res_next.group_index = GIDX_W'(gsel);
            cnt_wdata            = b_dec;
            used_clr             = 1'b1;
            if (b_dec == '0) begin
              valid_clr                = 1'b1;
              res_next.released_valid  = 1'b1;
              res_next.released_bank   = BIDX_W'(bsel);
            end
          end
          default: begin
            cnt_wdata = b_sub;
            if ((rm_cnt != '0) && (b_sub == '0)) begin
              valid_clr               = 1'b1;
              res_next.released_valid = 1'b1;
              res_next.released_bank  = BIDX_W'(bsel);
            end
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control and occupancy registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      sid_bits   <= SID_BITS_RESET;
      bank_valid <= '0;
      grp_used   <= '0;
      rel_v      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (fin) begin
        result <= res_next;
      end
      if (psel && penable && pwrite && (paddr[CFG_AW-1:2] == CFG_IDX_SID_BITS)) begin
        sid_bits <= pwdata[SID_BITS_W-1:0];
      end
      if (accept) begin
        req    <= request;
        rel_v  <= 1'b0;
        b_cnt  <= '0;
        rm_cnt <= '0;
      end
      if ((state == S_BSCAN) && match && !flags.hit) begin
        b_cnt <= cnt_rd;
      end
      if ((state == S_BSCAN) && flags.done) begin
        bsel     <= flags.hit ? hit_b : free_b;
        bank_new <= !flags.hit;
      end
      if ((state == S_GSCAN) && match && !flags.hit) begin
        gb <= gbank_rd;
      end
      if ((state == S_GSCAN) && flags.done) begin
        gsel <= flags.hit ? hit_g : free_g;
      end
      if ((state == S_RSCAN) && match) begin
        grp_used[cmp_g] <= 1'b0;
        rm_cnt          <= rm_cnt + 1'b1;
      end
      if (used_set) begin
        grp_used[gsel] <= 1'b1;
      end
      if (used_clr) begin
        grp_used[gsel] <= 1'b0;
      end
      if (valid_set) begin
        bank_valid[bsel] <= 1'b1;
      end
      if (valid_clr) begin
        bank_valid[valid_clr_idx] <= 1'b0;
      end
      if (rel_set) begin
        rel_v <= 1'b1;
        rel_b <= rel_idx;
      end
    end
  end

  // table memories: one registered read and one write each per cycle
  always_ff @(posedge clk) begin
    addr_rd   <= bank_addr_mem[rd_b];
    cnt_rd    <= bank_cnt_mem[cnt_raddr];
    stream_rd <= grp_stream_mem[rd_g];
    gbank_rd  <= grp_bank_mem[rd_g];
    if (addr_we) begin
      bank_addr_mem[bsel] <= req.table_address;
    end
    if (cnt_we) begin
      bank_cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (grp_we) begin
      grp_stream_mem[gsel] <= req.sid;
      grp_bank_mem[gsel]   <= bsel;
    end
  end

  assign prdata = (paddr[CFG_AW-1:2] == CFG_IDX_SID_BITS) ? CFG_DW'(sid_bits) : '0;

endmodule
